/* hw/rtl/csp_pkg.sv */
// Shared types and constants for the counting sort permutation unit.
// Used by the top level; no dependencies of its own.
package csp_pkg;

    // Default sizing of the batch store and key range
    localparam int DEF_MAX_ITEMS    = 1024;
    localparam int DEF_MAX_KEY_BITS = 8;

    // Fixed field widths of the stream items
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 31;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int KB_W       = 5;

    localparam logic [CFG_IDX_W-1:0]  REG_KEY_BITS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_MASK_KEYS = 1'd1;
    localparam logic [CFG_DATA_W-1:0] KEY_BITS_RST  = 4'd8;

    // Item kinds carried in tuser
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HIST,
        ST_PREFIX,
        ST_SCATTER,
        ST_DRAIN
    } t_state;

    // Sub-steps of one element or bucket inside a sort pass
    typedef enum logic [1:0] {
        PH_ADDR,
        PH_BUCKET,
        PH_UPDATE
    } t_phase;

endpackage

/* hw/rtl/counting_sort_permutation_unit.sv */
// Counting sort permutation unit: stable sort of a batch of payloads by small keys.
// Depends on csp_pkg and csp_ram.
//
// Load transfers (tuser 0) append a key and payload; the one with tlast closes
// the batch and starts the sort, during which the unit is not ready. The sort
// runs bucket clear, histogram, prefix sum and scatter over B = 2^key_bits
// buckets, paced by the registered read of the bucket RAM and one shared adder;
// each element takes three steps (key read, bucket read, bucket write). A drain
// transfer (tuser 1) reads the sorted RAM, then moves the word into the output
// register once the output is free; a drain may be accepted while an earlier
// result still waits. A load after a sorted batch starts a new batch. Result
// tuser flags an out-of-range key in unmasked mode, result tlast marks the final
// payload of the batch.
module counting_sort_permutation_unit #(
    parameter int MAX_ITEMS    = csp_pkg::DEF_MAX_ITEMS,
    parameter int MAX_KEY_BITS = csp_pkg::DEF_MAX_KEY_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [csp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [csp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [csp_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // key[31:0], payload[62:32], 0
    input  logic                           s_axis_tlast,  // last
    input  logic                           s_axis_tuser,  // mode
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [csp_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // sorted_payload[30:0], 0
    output logic                           m_axis_tlast,  // final_res
    output logic                           m_axis_tuser   // key_error
);

    import csp_pkg::*;

    localparam int AW   = $clog2(MAX_ITEMS);
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int MKB  = MAX_KEY_BITS;
    localparam int NBUK = 1 << MAX_KEY_BITS;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_key_bits;
    logic                  r_mask_keys;

    // Control state
    t_state         r_state, n_state;
    t_phase         r_phase, n_phase;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_ptr,   n_ptr;
    logic [CW-1:0]  r_idx,   n_idx;
    logic [CW-1:0]  r_sum,   n_sum;
    logic [MKB:0]   r_bkt,   n_bkt;
    logic           r_err,   n_err;
    logic           r_ready_batch, n_ready_batch;
    logic           r_drn_last, n_drn_last;
    logic           r_drn_err,  n_drn_err;

    // Output register
    logic                 r_m_valid, n_m_valid;
    logic [PAYLOAD_W-1:0] r_m_payload, n_m_payload;
    logic                 r_m_last,  n_m_last;
    logic                 r_m_err,   n_m_err;

    // Input fields
    logic [KEY_W-1:0]     w_key;
    logic [PAYLOAD_W-1:0] w_payload;
    logic                 w_s_xfer;
    logic                 w_m_free;

    // Key range
    logic [KB_W-1:0] w_kb;
    logic [MKB:0]    w_nb;
    logic [MKB:0]    w_nb_m1;
    logic [MKB-1:0]  w_bmask;
    logic            w_key_oor;

    // Shared adder
    logic [CW-1:0] w_add_a, w_add_b, w_add_sum;

    // RAM ports
    logic                 w_key_we, w_key_re;
    logic [AW-1:0]        w_key_waddr, w_key_raddr;
    logic [MKB-1:0]       w_key_wdata, w_key_rd;
    logic                 w_pay_we, w_pay_re;
    logic [AW-1:0]        w_pay_waddr, w_pay_raddr;
    logic [PAYLOAD_W-1:0] w_pay_wdata, w_pay_rd;
    logic                 w_srt_we, w_srt_re;
    logic [AW-1:0]        w_srt_waddr, w_srt_raddr;
    logic [PAYLOAD_W-1:0] w_srt_wdata, w_srt_rd;
    logic                 w_bkt_we, w_bkt_re;
    logic [MKB-1:0]       w_bkt_waddr, w_bkt_raddr;
    logic [CW-1:0]        w_bkt_wdata, w_bkt_rd;
    logic [MKB-1:0]       w_key_bkt;

    assign w_key     = s_axis_tdata[KEY_W-1:0];
    assign w_payload = s_axis_tdata[KEY_W +: PAYLOAD_W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_s_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_m_free  = !r_m_valid || m_axis_tready;

    // Clamp key_bits into the supported range
    always_comb begin
        priority if (r_key_bits == '0) begin
            w_kb = KB_W'(1);
        end else if ({1'b0, r_key_bits} > KB_W'(MAX_KEY_BITS)) begin
            w_kb = KB_W'(MAX_KEY_BITS);
        end else begin
            w_kb = {1'b0, r_key_bits};
        end
    end

    assign w_nb      = (MKB+1)'(1) << w_kb;
    assign w_nb_m1   = w_nb - (MKB+1)'(1);
    assign w_bmask   = w_nb_m1[MKB-1:0];
    assign w_key_oor = (w_key >> w_kb) != '0;
    assign w_key_bkt = w_key_rd & w_bmask;
    assign w_add_sum = w_add_a + w_add_b;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bits  <= KEY_BITS_RST;
            r_mask_keys <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_KEY_BITS) begin
                r_key_bits <= i_cfg_data;
            end
            if (i_cfg_idx == REG_MASK_KEYS) begin
                r_mask_keys <= i_cfg_data[0];
            end
        end
    end

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_xfer) begin
                    if (s_axis_tuser == MODE_LOAD) begin
                        if (s_axis_tlast) begin
                            n_state = ST_CLEAR;
                        end
                    end else if (r_ready_batch && (r_ptr < r_count)) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_CLEAR: begin
                if (r_bkt == w_nb_m1) begin
                    n_state = ST_HIST;
                end
            end
            ST_HIST: begin
                if (r_phase == PH_ADDR && r_idx == r_count) begin
                    n_state = ST_PREFIX;
                end
            end
            ST_PREFIX: begin
                if (r_phase == PH_ADDR && r_bkt == w_nb) begin
                    n_state = ST_SCATTER;
                end
            end
            ST_SCATTER: begin
                if (r_phase == PH_ADDR && r_idx == r_count) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (w_m_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control, RAM ports and register updates
    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_ptr         = r_ptr;
        n_idx         = r_idx;
        n_sum         = r_sum;
        n_bkt         = r_bkt;
        n_err         = r_err;
        n_ready_batch = r_ready_batch;
        n_drn_last    = r_drn_last;
        n_drn_err     = r_drn_err;
        n_m_payload   = r_m_payload;
        n_m_last      = r_m_last;
        n_m_err       = r_m_err;
        n_m_valid     = r_m_valid && !m_axis_tready;

        w_add_a = r_count;
        w_add_b = CW'(1);

        w_key_we = 1'b0;  w_key_re = 1'b0;
        w_key_waddr = r_count[AW-1:0];
        w_key_raddr = r_idx[AW-1:0];
        w_key_wdata = w_key[MKB-1:0];
        w_pay_we = 1'b0;  w_pay_re = 1'b0;
        w_pay_waddr = r_count[AW-1:0];
        w_pay_raddr = r_idx[AW-1:0];
        w_pay_wdata = w_payload;
        w_srt_we = 1'b0;  w_srt_re = 1'b0;
        w_srt_waddr = w_bkt_rd[AW-1:0];
        w_srt_raddr = r_ptr[AW-1:0];
        w_srt_wdata = w_pay_rd;
        w_bkt_we = 1'b0;  w_bkt_re = 1'b0;
        w_bkt_waddr = w_key_bkt;
        w_bkt_raddr = w_key_bkt;
        w_bkt_wdata = w_add_sum;

        unique case (r_state)
            ST_IDLE: begin
                if (w_s_xfer && s_axis_tuser == MODE_LOAD) begin
                    // Append to the batch, opening a new one after a sorted batch
                    if (r_ready_batch) begin
                        n_ready_batch = 1'b0;
                        w_add_a       = '0;
                        n_ptr         = '0;
                        n_err         = !r_mask_keys && w_key_oor;
                    end else begin
                        n_err = r_err || (!r_mask_keys && w_key_oor);
                    end
                    if (w_add_a < CW'(MAX_ITEMS)) begin
                        w_key_we    = 1'b1;
                        w_pay_we    = 1'b1;
                        w_key_waddr = w_add_a[AW-1:0];
                        w_pay_waddr = w_add_a[AW-1:0];
                        n_count     = w_add_sum;
                    end else begin
                        n_count = w_add_a;
                    end
                    if (s_axis_tlast) begin
                        n_bkt = '0;
                    end
                end else if (w_s_xfer && r_ready_batch && (r_ptr < r_count)) begin
                    // Fetch the next sorted payload
                    w_srt_re   = 1'b1;
                    w_add_a    = r_ptr;
                    n_ptr      = w_add_sum;
                    n_drn_last = (w_add_sum == r_count);
                    n_drn_err  = r_err;
                end
            end
            ST_CLEAR: begin
                w_bkt_we    = 1'b1;
                w_bkt_waddr = r_bkt[MKB-1:0];
                w_bkt_wdata = '0;
                n_bkt       = r_bkt + (MKB+1)'(1);
                if (r_bkt == w_nb_m1) begin
                    n_idx   = '0;
                    n_phase = PH_ADDR;
                end
            end
            ST_HIST, ST_SCATTER: begin
                unique case (r_phase)
                    PH_ADDR: begin
                        if (r_idx == r_count) begin
                            n_idx = '0;
                            n_bkt = '0;
                            n_sum = '0;
                            if (r_state == ST_SCATTER) begin
                                n_ready_batch = 1'b1;
                                n_ptr         = '0;
                            end
                        end else begin
                            w_key_re = 1'b1;
                            w_pay_re = (r_state == ST_SCATTER);
                            n_phase  = PH_BUCKET;
                        end
                    end
                    PH_BUCKET: begin
                        w_bkt_re = 1'b1;
                        n_phase  = PH_UPDATE;
                    end
                    PH_UPDATE: begin
                        // Bump the bucket; in scatter place the payload at its old value
                        w_add_a  = w_bkt_rd;
                        w_bkt_we = 1'b1;
                        w_srt_we = (r_state == ST_SCATTER);
                        n_idx    = r_idx + CW'(1);
                        n_phase  = PH_ADDR;
                    end
                    default: n_phase = PH_ADDR;
                endcase
            end
            ST_PREFIX: begin
                unique case (r_phase)
                    PH_ADDR: begin
                        if (r_bkt == w_nb) begin
                            n_idx = '0;
                        end else begin
                            w_bkt_re    = 1'b1;
                            w_bkt_raddr = r_bkt[MKB-1:0];
                            n_phase     = PH_BUCKET;
                        end
                    end
                    PH_BUCKET: begin
                        // Replace the count by the running sum
                        w_add_a     = r_sum;
                        w_add_b     = w_bkt_rd;
                        w_bkt_we    = 1'b1;
                        w_bkt_waddr = r_bkt[MKB-1:0];
                        w_bkt_wdata = r_sum;
                        n_sum       = w_add_sum;
                        n_bkt       = r_bkt + (MKB+1)'(1);
                        n_phase     = PH_ADDR;
                    end
                    default: n_phase = PH_ADDR;
                endcase
            end
            ST_DRAIN: begin
                if (w_m_free) begin
                    n_m_valid   = 1'b1;
                    n_m_payload = w_srt_rd;
                    n_m_last    = r_drn_last;
                    n_m_err     = r_drn_err;
                end
            end
            default: n_phase = PH_ADDR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= PH_ADDR;
            r_count       <= '0;
            r_ptr         <= '0;
            r_idx         <= '0;
            r_sum         <= '0;
            r_bkt         <= '0;
            r_err         <= 1'b0;
            r_ready_batch <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_count       <= n_count;
            r_ptr         <= n_ptr;
            r_idx         <= n_idx;
            r_sum         <= n_sum;
            r_bkt         <= n_bkt;
            r_err         <= n_err;
            r_ready_batch <= n_ready_batch;
            r_m_valid     <= n_m_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_drn_last  <= n_drn_last;
        r_drn_err   <= n_drn_err;
        r_m_payload <= n_m_payload;
        r_m_last    <= n_m_last;
        r_m_err     <= n_m_err;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-PAYLOAD_W){1'b0}}, r_m_payload};
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_err;

    // Stores
    csp_ram #(.WIDTH(MKB), .DEPTH(MAX_ITEMS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_key_waddr),
        .i_wdata (w_key_wdata),
        .i_re    (w_key_re),
        .i_raddr (w_key_raddr),
        .o_rdata (w_key_rd)
    );

    csp_ram #(.WIDTH(PAYLOAD_W), .DEPTH(MAX_ITEMS)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (w_pay_we),
        .i_waddr (w_pay_waddr),
        .i_wdata (w_pay_wdata),
        .i_re    (w_pay_re),
        .i_raddr (w_pay_raddr),
        .o_rdata (w_pay_rd)
    );

    csp_ram #(.WIDTH(PAYLOAD_W), .DEPTH(MAX_ITEMS)) u_srt_ram (
        .i_clk   (i_clk),
        .i_we    (w_srt_we),
        .i_waddr (w_srt_waddr),
        .i_wdata (w_srt_wdata),
        .i_re    (w_srt_re),
        .i_raddr (w_srt_raddr),
        .o_rdata (w_srt_rd)
    );

    csp_ram #(.WIDTH(CW), .DEPTH(NBUK)) u_bkt_ram (
        .i_clk   (i_clk),
        .i_we    (w_bkt_we),
        .i_waddr (w_bkt_waddr),
        .i_wdata (w_bkt_wdata),
        .i_re    (w_bkt_re),
        .i_raddr (w_bkt_raddr),
        .o_rdata (w_bkt_rd)
    );

endmodule

/* hw/rtl/csp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; instanced for every store of the sort unit.
module csp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sim/counting_sort_permutation_unit_tb.sv */
// Self-checking testbench for the counting sort permutation unit.
// Drives load and drain transfers, predicts each sorted payload and compares
// every result transfer against it. Depends on csp_pkg and the unit's RTL.
module counting_sort_permutation_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csp_pkg::*;

    localparam int ITEM_CAP     = DEF_MAX_ITEMS;
    localparam int KEY_CAP_BITS = DEF_MAX_KEY_BITS;
    localparam int NUM_BUCKETS  = 1 << KEY_CAP_BITS;
    localparam int RAND_ITEMS   = 250;
    localparam int FULL_DRAINS  = 16;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DIR_ROWS     = 17;

    // Register settings of the first random phases, extremes first
    localparam logic [CFG_DATA_W-1:0] KB_PLAN [5] = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd5};
    localparam logic MASK_PLAN [5] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    // Directed rows: expectation typed in, or left to the predictor
    localparam logic FROM_PRED = 1'b0;
    localparam logic TYPED     = 1'b1;
    localparam logic NO_RES    = 1'b0;
    localparam logic ONE_RES   = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } item_t;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic                 final_res;
        logic                 key_error;
    } result_t;

    typedef struct packed {
        logic                 mode;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
        logic                 typed;
        logic                 has_res;
        logic [PAYLOAD_W-1:0] res_payload;
        logic                 res_final;
        logic                 res_err;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    // Predictor state
    logic [CFG_DATA_W-1:0]   kb_reg   = KEY_BITS_RST;
    logic                    mask_reg = 1'b0;
    logic [KEY_CAP_BITS-1:0] loaded_key [ITEM_CAP];
    logic [PAYLOAD_W-1:0]    loaded_pay [ITEM_CAP];
    logic [PAYLOAD_W-1:0]    sorted_pay [ITEM_CAP];
    int unsigned             bucket_pos [NUM_BUCKETS];
    int unsigned             item_cnt     = 0;
    int unsigned             drain_ptr    = 0;
    bit                      batch_err    = 1'b0;
    bit                      batch_sorted = 1'b0;

    result_t     payloads_due [$];
    int unsigned mismatches = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned loads_left = 0;
    int unsigned drains_left = 0;
    bit          src_idle   = 1'b1;
    bit          sink_idle  = 1'b1;
    int unsigned sink_wait  = 0;
    dir_row_t    dir_rows [DIR_ROWS];

    counting_sort_permutation_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Key bits in force: zero acts as one, anything wide is clamped
    function automatic int unsigned active_key_bits();
        int unsigned kb;
        kb = kb_reg;
        if (kb < 1) kb = 1;
        if (kb > KEY_CAP_BITS) kb = KEY_CAP_BITS;
        return kb;
    endfunction

    // Histogram, exclusive prefix sum and stable scatter of the loaded batch
    function automatic void sort_loaded_batch();
        int unsigned msk;
        int unsigned sum;
        int unsigned h;
        int unsigned b;
        msk = (1 << active_key_bits()) - 1;
        sum = 0;
        foreach (bucket_pos[i]) bucket_pos[i] = 0;
        for (int unsigned i = 0; i < item_cnt; i++) bucket_pos[loaded_key[i] & msk]++;
        for (int unsigned i = 0; i <= msk; i++) begin
            h = bucket_pos[i];
            bucket_pos[i] = sum;
            sum += h;
        end
        for (int unsigned i = 0; i < item_cnt; i++) begin
            b = loaded_key[i] & msk;
            sorted_pay[bucket_pos[b]] = loaded_pay[i];
            bucket_pos[b]++;
        end
        drain_ptr    = 0;
        batch_sorted = 1'b1;
    endfunction

    // Advance the predictor by one accepted transfer; returns 1 with a result
    function automatic bit step_sorter(input item_t it, output result_t res);
        res = '0;
        if (it.mode == MODE_LOAD) begin
            // a load after a sorted batch opens a new one
            if (batch_sorted) begin
                batch_sorted = 1'b0;
                item_cnt     = 0;
                drain_ptr    = 0;
                batch_err    = 1'b0;
            end
            if (!mask_reg && (it.key >> active_key_bits()) != 0) batch_err = 1'b1;
            // drop loads beyond the batch store
            if (item_cnt < ITEM_CAP) begin
                loaded_key[item_cnt] = it.key[KEY_CAP_BITS-1:0];
                loaded_pay[item_cnt] = it.payload;
                item_cnt++;
            end
            if (it.last) sort_loaded_batch();
            return 1'b0;
        end
        if (!batch_sorted || drain_ptr >= item_cnt) return 1'b0;
        res.payload   = sorted_pay[drain_ptr];
        res.final_res = (drain_ptr + 1 == item_cnt);
        res.key_error = batch_err;
        drain_ptr++;
        return 1'b1;
    endfunction

    // Keys: mostly in range, with the range edges and wide random keys mixed in
    function automatic logic [KEY_W-1:0] pick_key(input int unsigned kbe);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return '0;
            2:       return (1 << kbe) - 1;
            3:       return 1 << kbe;
            default: return $urandom_range(0, (1 << kbe) - 1);
        endcase
    endfunction

    // Drain request with random content in the fields it ignores
    function automatic item_t drain_item();
        item_t it;
        it.mode    = MODE_DRAIN;
        it.key     = $urandom;
        it.payload = PAYLOAD_W'($urandom);
        it.last    = 1'($urandom);
        return it;
    endfunction

    // Batch stream: loads then drains, with stray drains and early closes as noise
    function automatic item_t next_item();
        item_t       it;
        int unsigned n;
        int unsigned pick;
        it = drain_item();
        if (loads_left == 0 && drains_left == 0) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) n = 0;
            else if (pick < 3) n = $urandom_range(25, 200);
            else n = $urandom_range(1, 24);
            loads_left  = n;
            drains_left = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n)
                                                      : n + $urandom_range(0, 2);
            if (n == 0) drains_left = $urandom_range(1, 3);
        end
        if (loads_left != 0) begin
            if ($urandom_range(0, 24) != 0) begin
                loads_left--;
                it.mode = MODE_LOAD;
                it.key  = pick_key(active_key_bits());
                it.last = (loads_left == 0) || ($urandom_range(0, 59) == 0);
            end
        end else begin
            drains_left--;
        end
        return it;
    endfunction

    // Present one transfer after a random gap and record what it should produce
    task automatic send_item(input item_t it, input logic typed, input logic typed_has,
                             input result_t typed_res, output bit counted);
        int unsigned gap;
        bit          got;
        result_t     res;
        gap = src_idle ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 39) == 0) src_idle = !src_idle;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - KEY_W - PAYLOAD_W){1'b0}}, it.payload, it.key};
        s_axis_tlast  <= it.last;
        s_axis_tuser  <= it.mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = step_sorter(it, res);
        if (typed) begin
            if (typed_has) payloads_due.push_back(typed_res);
        end else if (got) begin
            payloads_due.push_back(res);
        end
        counted = (it.mode == MODE_LOAD) || got;
        @(negedge i_clk);
    endtask

    // Hold the input until every result is in and a full sort could have run
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (payloads_due.size() != 0) @(negedge i_clk);
        repeat (3 * NUM_BUCKETS + 6 * item_cnt + 16) @(negedge i_clk);
    endtask

    task automatic write_regs(input bit wr_kb, input logic [CFG_DATA_W-1:0] kb,
                              input bit wr_mask, input logic mask);
        if (wr_kb) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_KEY_BITS;
            i_cfg_data <= kb;
            kb_reg     = kb;
            @(negedge i_clk);
        end
        if (wr_mask) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_MASK_KEYS;
            i_cfg_data <= CFG_DATA_W'(mask);
            mask_reg   = mask;
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Result sink: random stall before each transfer
    always @(negedge i_clk) begin
        if (sink_wait != 0) begin
            m_axis_tready <= 1'b0;
            sink_wait--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest pending one
    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (payloads_due.size() == 0) begin
                $error("result with nothing pending: sorted_payload %h",
                       m_axis_tdata[PAYLOAD_W-1:0]);
                mismatches++;
            end else begin
                want = payloads_due.pop_front();
                if (m_axis_tdata[PAYLOAD_W-1:0] !== want.payload) begin
                    $error("sorted_payload: expected %h, got %h", want.payload,
                           m_axis_tdata[PAYLOAD_W-1:0]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.final_res) begin
                    $error("final_res: expected %b, got %b", want.final_res, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser !== want.key_error) begin
                    $error("key_error: expected %b, got %b", want.key_error, m_axis_tuser);
                    mismatches++;
                end
            end
            sink_wait = sink_idle ? $urandom_range(0, 16) : 0;
            if ($urandom_range(0, 29) == 0) sink_idle = !sink_idle;
        end
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("counting_sort_permutation_unit_tb NOT OK");
        $finish;
    end

    initial begin
        item_t       it;
        result_t     want;
        bit          counted;
        bit          wk;
        int unsigned rand_count;
        int unsigned phase;

        // Reset configuration: eight key bits, unmasked
        dir_rows = '{
            // drain straight after reset: nothing sorted yet
            '{MODE_DRAIN, 32'h0000_0000, 31'h0000_0000, 1'b0, TYPED, NO_RES,
              31'h0, 1'b0, 1'b0},
            // batch with a duplicate key, a zero key and a full-width key
            '{MODE_LOAD, 32'd3, 31'h7FFF_FFFF, 1'b0, FROM_PRED, NO_RES, 31'h0, 1'b0, 1'b0},
            '{MODE_LOAD, 32'd0, 31'h0000_0000, 1'b0, FROM_PRED, NO_RES, 31'h0, 1'b0, 1'b0},
            '{MODE_LOAD, 32'd3, 31'h0000_0005, 1'b0, FROM_PRED, NO_RES, 31'h0, 1'b0, 1'b0},
            '{MODE_LOAD, 32'hFFFF_FFFF, 31'h5555_5555, 1'b1, FROM_PRED, NO_RES,
              31'h0, 1'b0, 1'b0},
            '{MODE_DRAIN, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, TYPED, ONE_RES,
              31'h0000_0000, 1'b0, 1'b1},
            '{MODE_DRAIN, 32'h0, 31'h0, 1'b0, TYPED, ONE_RES, 31'h7FFF_FFFF, 1'b0, 1'b1},
            '{MODE_DRAIN, 32'h0, 31'h0, 1'b0, TYPED, ONE_RES, 31'h0000_0005, 1'b0, 1'b1},
            '{MODE_DRAIN, 32'h0, 31'h0, 1'b0, TYPED, ONE_RES, 31'h5555_5555, 1'b1, 1'b1},
            // drain past the final payload
            '{MODE_DRAIN, 32'h0, 31'h0, 1'b0, TYPED, NO_RES, 31'h0, 1'b0, 1'b0},
            // single-item batch at the top key in range clears the error
            '{MODE_LOAD, 32'd255, 31'h2AAA_AAAA, 1'b1, FROM_PRED, NO_RES, 31'h0, 1'b0, 1'b0},
            '{MODE_DRAIN, 32'h0, 31'h0, 1'b0, TYPED, ONE_RES, 31'h2AAA_AAAA, 1'b1, 1'b0},
            // first key out of range, then a drain while the batch is still open
            '{MODE_LOAD, 32'd256, 31'h0000_0001, 1'b0, FROM_PRED, NO_RES, 31'h0, 1'b0, 1'b0},
            '{MODE_DRAIN, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, TYPED, NO_RES,
              31'h0, 1'b0, 1'b0},
            '{MODE_LOAD, 32'd1, 31'h0000_0002, 1'b1, FROM_PRED, NO_RES, 31'h0, 1'b0, 1'b0},
            '{MODE_DRAIN, 32'h0, 31'h0, 1'b0, FROM_PRED, NO_RES, 31'h0, 1'b0, 1'b0},
            '{MODE_DRAIN, 32'h0, 31'h0, 1'b0, FROM_PRED, NO_RES, 31'h0, 1'b0, 1'b0}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows
        foreach (dir_rows[r]) begin
            it   = '{dir_rows[r].mode, dir_rows[r].key, dir_rows[r].payload, dir_rows[r].last};
            want = '{dir_rows[r].res_payload, dir_rows[r].res_final, dir_rows[r].res_err};
            send_item(it, dir_rows[r].typed, dir_rows[r].has_res, want, counted);
        end

        // Overfull batch: loads past the store are dropped, the last one still sorts;
        // drain the head of the sorted batch only
        settle_idle();
        write_regs(1'b1, 4'd4, 1'b1, 1'b0);
        for (int i = 0; i < ITEM_CAP + 3; i++) begin
            it.mode    = MODE_LOAD;
            it.key     = pick_key(active_key_bits());
            it.payload = PAYLOAD_W'($urandom);
            it.last    = (i == ITEM_CAP + 2);
            send_item(it, 1'b0, 1'b0, '0, counted);
        end
        for (int i = 0; i < FULL_DRAINS; i++) send_item(drain_item(), 1'b0, 1'b0, '0, counted);

        // Random phases, each under its own register setting
        rand_count = 0;
        phase      = 0;
        while (rand_count < RAND_ITEMS) begin
            settle_idle();
            if (phase < 5) begin
                write_regs(1'b1, KB_PLAN[phase], 1'b1, MASK_PLAN[phase]);
            end else begin
                wk = 1'($urandom);
                write_regs(wk, CFG_DATA_W'($urandom_range(0, 15)),
                           !wk || 1'($urandom), 1'($urandom));
            end
            repeat ($urandom_range(30, 70)) begin
                send_item(next_item(), 1'b0, 1'b0, '0, counted);
                if (counted) rand_count++;
            end
            phase++;
        end

        settle_idle();
        if (mismatches == 0) begin
            $display("counting_sort_permutation_unit_tb OK");
        end else begin
            $display("counting_sort_permutation_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
